// File: design/rrp_pkg.sv
// Package for the reply parser: byte codes, parser phases, event kinds and
// the record passed from the front stage to the event queue. No dependencies.
package rrp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    EV_INT    = 3'd0,
    EV_SIMPLE = 3'd1,
    EV_BULK   = 3'd2,
    EV_ERRB   = 3'd3,
    EV_STREND = 3'd4,
    EV_NULL   = 3'd5,
    EV_ARRAY  = 3'd6,
    EV_PERR   = 3'd7
  } ev_kind_t;

  typedef enum logic [10:0] {
    PH_TYPE      = 11'b00000000001,
    PH_LINE      = 11'b00000000010,
    PH_LINE_LF   = 11'b00000000100,
    PH_NUM_FIRST = 11'b00000001000,
    PH_NUM_SIGN  = 11'b00000010000,
    PH_NUM       = 11'b00000100000,
    PH_NUM_LF    = 11'b00001000000,
    PH_BULK_DATA = 11'b00010000000,
    PH_BULK_CR   = 11'b00100000000,
    PH_BULK_LF   = 11'b01000000000,
    PH_RESYNC    = 11'b10000000000
  } phase_t;

  typedef enum logic [2:0] {
    TY_INT    = 3'd0,
    TY_SIMPLE = 3'd1,
    TY_BULK   = 3'd2,
    TY_ERROR  = 3'd3,
    TY_ARRAY  = 3'd4
  } rtype_t;

  // Front-stage result: one event ready to leave the block.
  typedef struct packed {
    ev_kind_t    kind;
    logic [63:0] value;
    logic [3:0]  depth;
    logic        done;
  } event_t;

endpackage

// File: design/rrp_front.sv
// Front stage: per-byte parser state machine, number accumulator and the
// stack of pending element counts. Uses rrp_pkg.
module rrp_front
  import rrp_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  byte_data,
  input  logic [31:0] max_bulk,
  output logic        ev_valid,
  output event_t      ev
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  phase_t      phase_r, phase_nxt;
  rtype_t      type_r, type_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] bulk_r, bulk_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [31:0] cnt_r [MAX_DEPTH];
  logic        cnt_we;
  logic [IW-1:0] cnt_wa;
  logic [31:0] cnt_wd;

  logic        digit;
  logic [3:0]  dval;
  logic        fin_found;
  logic [IW-1:0] fin_idx;
  logic        fin_done;
  logic [LW-1:0] fin_lvl;

  assign digit   = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
  assign dval    = 4'(byte_data - CH_ZERO);

  // Retiring an element pops every open array, from the top down, that was
  // waiting for its last element; the first one that still owes more is
  // decremented. The reply is done when no open array is left.
  always_comb begin
    fin_found = 1'b0;
    fin_idx   = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LW'(i) < lvl_r && cnt_r[i] != 32'd1) begin
        fin_found = 1'b1;
        fin_idx   = IW'(i);
      end
    end
    fin_done = !fin_found;
    fin_lvl  = fin_found ? (LW'(fin_idx) + LW'(1)) : '0;
  end

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    bulk_nxt  = bulk_r;
    lvl_nxt   = lvl_r;
    cnt_we    = 1'b0;
    cnt_wa    = '0;
    cnt_wd    = '0;
    ev_valid  = 1'b0;
    ev.kind   = EV_PERR;
    ev.value  = '0;
    ev.depth  = 4'(lvl_r);
    ev.done   = 1'b0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_TYPE: begin
          acc_nxt = '0;
          neg_nxt = 1'b0;
          phase_nxt = PH_NUM_FIRST;
          priority if (byte_data == CH_COLON) type_nxt = TY_INT;
          else if (byte_data == CH_DOLLAR) type_nxt = TY_BULK;
          else if (byte_data == CH_STAR) type_nxt = TY_ARRAY;
          else if (byte_data == CH_PLUS && lvl_r == '0) begin
            type_nxt = TY_SIMPLE;
            phase_nxt = PH_LINE;
          end else if (byte_data == CH_MINUS && lvl_r == '0) begin
            type_nxt = TY_ERROR;
            phase_nxt = PH_LINE;
          end else begin
            ev_valid = 1'b1;
          end
        end
        PH_LINE: begin
          if (byte_data == CH_CR) phase_nxt = PH_LINE_LF;
          else if (byte_data == CH_LF) ev_valid = 1'b1;
          else begin
            ev_valid = 1'b1;
            ev.kind  = (type_r == TY_ERROR) ? EV_ERRB : EV_SIMPLE;
            ev.value = {56'd0, byte_data};
          end
        end
        PH_LINE_LF, PH_BULK_LF: begin
          ev_valid = 1'b1;
          if (byte_data == CH_LF) begin
            phase_nxt = PH_TYPE;
            ev.kind = EV_STREND;
          end
        end
        PH_NUM_FIRST, PH_NUM_SIGN: begin
          if (phase_r == PH_NUM_FIRST && byte_data == CH_MINUS) begin
            neg_nxt = 1'b1;
            phase_nxt = PH_NUM_SIGN;
          end else if (digit) begin
            acc_nxt = {60'd0, dval};
            phase_nxt = PH_NUM;
          end else ev_valid = 1'b1;
        end
        PH_NUM: begin
          if (byte_data == CH_CR) phase_nxt = PH_NUM_LF;
          else if (digit) acc_nxt = (acc_r << 3) + (acc_r << 1) + {60'd0, dval};
          else ev_valid = 1'b1;
        end
        PH_NUM_LF: begin
          ev_valid = 1'b1;
          if (byte_data == CH_LF) begin
            phase_nxt = PH_TYPE;
            if (type_r == TY_BULK) begin
              if (neg_r) ev.kind = EV_NULL;
              else if (acc_r > {32'd0, max_bulk}) ev.kind = EV_PERR;
              else begin
                ev_valid = 1'b0;
                bulk_nxt = acc_r[31:0];
                phase_nxt = (acc_r == '0) ? PH_BULK_CR : PH_BULK_DATA;
              end
            end else if (type_r == TY_ARRAY) begin
              if (neg_r) ev.kind = EV_NULL;
              else if (acc_r == '0) ev.kind = EV_ARRAY;
              else if (lvl_r >= LW'(MAX_DEPTH) || acc_r[63:32] != '0) ev.kind = EV_PERR;
              else begin
                ev.kind  = EV_ARRAY;
                ev.value = acc_r;
                cnt_we   = 1'b1;
                cnt_wa   = IW'(lvl_r);
                cnt_wd   = acc_r[31:0];
                lvl_nxt  = lvl_r + LW'(1);
              end
            end else begin
              ev.kind  = EV_INT;
              ev.value = neg_r ? (64'd0 - acc_r) : acc_r;
            end
          end
        end
        PH_BULK_DATA: begin
          ev_valid = 1'b1;
          ev.kind  = EV_BULK;
          ev.value = {56'd0, byte_data};
          bulk_nxt = bulk_r - 32'd1;
          if (bulk_r == 32'd1) phase_nxt = PH_BULK_CR;
        end
        PH_BULK_CR: begin
          if (byte_data == CH_CR) phase_nxt = PH_BULK_LF;
          else ev_valid = 1'b1;
        end
        PH_RESYNC: begin
          if (byte_data == CH_LF) phase_nxt = PH_TYPE;
        end
        default: phase_nxt = PH_TYPE;
      endcase
      // Element completion for integer, string-end, null and empty-array events only.
      if (ev_valid && ev.kind != EV_PERR && ev.kind != EV_SIMPLE && ev.kind != EV_ERRB
          && ev.kind != EV_BULK && !(ev.kind == EV_ARRAY && ev.value != '0)) begin
        ev.done = fin_done;
        lvl_nxt = fin_lvl;
        cnt_we  = fin_found;
        cnt_wa  = fin_idx;
        cnt_wd  = cnt_r[fin_idx] - 32'd1;
      end
      if (ev_valid && ev.kind == EV_PERR) begin
        lvl_nxt = '0;
        phase_nxt = (byte_data == CH_LF) ? PH_TYPE : PH_RESYNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      type_r  <= TY_INT;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      bulk_r  <= '0;
      lvl_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      bulk_r  <= bulk_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  // Pending counts; entries are only read after being written.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_r[cnt_wa] <= cnt_wd;
  end

endmodule

// File: design/rrp_queue.sv
// Two-entry event queue between the front event register and the output port.
// Uses rrp_pkg for the event record.
module rrp_queue
  import rrp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  event_t wr_data,
  output logic   full,
  output logic   rd_valid,
  input  logic   rd_en,
  output event_t rd_data
);

  event_t     mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// File: design/resp_reply_parser.sv
// Top level of the reply parser: front stage, event queue and output port.
// Depends on rrp_pkg, rrp_front and rrp_queue.
//
// Usage: reply bytes enter on in_tdata, one transfer per byte. Each byte
// yields zero or one event on the out_ channel: out_tdata carries the
// value, out_tuser the kind, depth and reply-done flag.
// The event of a taken byte sits in the front event register after the
// edge that takes the byte, then is written into the queue, from which it
// can be transferred.
// Throughput: one byte per cycle while the receiver keeps up.
// cfg_wr_en writes max_bulk_length at once; write it only when idle.
// Reset (rst_n low, synchronous) empties the queue, closes all open arrays
// and sets max_bulk_length to 1024.
// When the receiver stalls, in_tready falls once the queue holds two events,
// or holds one while another waits in the front event register and no
// output transfer takes place in that cycle; in that second case in_tready
// follows out_tready within the same cycle.
module resp_reply_parser
  import rrp_pkg::*;
#(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // event_value
  output logic [7:0]  out_tuser,  // event_kind[2:0], nest_depth[6:3], reply_done[7]
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0] max_bulk_r;
  logic        ev_valid, ev_valid_r;
  event_t      ev, ev_r, q_data;
  logic        q_full, q_valid, take;

  // Config register.
  always_ff @(posedge clk) begin
    if (!rst_n) max_bulk_r <= 32'd1024;
    else if (cfg_wr_en) max_bulk_r <= cfg_wr_data;
  end

  // Accept only when the queue has room for an event still in flight.
  assign take      = in_tvalid && in_tready;
  assign in_tready = !q_full && !(ev_valid_r && q_valid && !(out_tvalid && out_tready));

  rrp_front #(.MAX_DEPTH(MAX_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .byte_valid(take), .byte_data(in_tdata),
    .max_bulk(max_bulk_r), .ev_valid(ev_valid), .ev(ev)
  );

  // Front event register.
  always_ff @(posedge clk) begin
    if (!rst_n) ev_valid_r <= 1'b0;
    else ev_valid_r <= ev_valid;
    ev_r <= ev;
  end

  rrp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(ev_valid_r), .wr_data(ev_r), .full(q_full),
    .rd_valid(q_valid), .rd_en(out_tvalid && out_tready), .rd_data(q_data)
  );

  assign out_tvalid = q_valid;
  assign out_tdata  = q_data.value;
  assign out_tuser  = {q_data.done, q_data.depth, q_data.kind};

endmodule

// File: design/resp_reply_parser_chk.sv
// Port-level checker for the reply parser, bound to the top level.
// Depends only on the top-level ports.
module resp_reply_parser_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [7:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  a_perr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == 3'd7 |-> out_tdata == 64'd0 && !out_tuser[7])
    else $error("protocol error event carries data");
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == 3'd1 || out_tuser[2:0] == 3'd2 ||
    out_tuser[2:0] == 3'd3) |-> out_tdata[63:8] == 56'd0 && !out_tuser[7])
    else $error("content byte event malformed");

endmodule

bind resp_reply_parser resp_reply_parser_chk u_chk (.*);
